[design/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock, disabled while the given reset is high.
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the usual clock and reset names.
`define ASSERT_CHK(label, prop, msg) \
   `ASSERT_AT(label, clock, reset, prop, msg)

`endif

[design/ikscache_pkg.sv]
// Beat layouts and operation codes of the interval-keyed size cache.
`timescale 1ns / 1ps

package ikscache_pkg;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_COMMIT = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic AXIS_H = 1'b0;
   localparam logic AXIS_V = 1'b1;

   localparam int REQ_DATA_W = 80;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 1;

   // Request tdata, lowest field last.
   typedef struct packed {
      logic [1:0]  zero_pad;
      logic [15:0] in_nat_baseline;
      logic [15:0] in_min_baseline;
      logic [14:0] in_natural;
      logic [14:0] in_minimum;
      logic [15:0] key_size;
   } req_data_type;

   typedef struct packed {
      logic       axis;
      logic [1:0] operation;
   } req_user_type;

   // Response tdata, lowest field last.
   typedef struct packed {
      logic [1:0]  zero_pad;
      logic [15:0] out_nat_baseline;
      logic [15:0] out_min_baseline;
      logic [14:0] out_natural;
      logic [14:0] out_minimum;
   } rsp_data_type;

endpackage

[design/interval_keyed_size_cache.sv]
// Interval-keyed size cache: two axes of cached size results kept in one entry memory.
// A base access, a clear or an unused code goes from accept straight to ST_RESP; a lookup or
// commit with a key of zero or more passes through ST_SCAN first, which compares up to ENTRIES
// entries at one memory read per cycle, stopping early on a match, before ST_RESP.
// ST_RESP moves the result into the output register once rsp drains; only ST_IDLE takes a new beat (one read port).
// Reset clears base valid bits, fill counts and replace pointers; the fill count marks live entries.
`timescale 1ns / 1ps

module interval_keyed_size_cache #(
   parameter int ENTRIES   = 4,
   parameter int SIZE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // key_size, in_minimum, in_natural, in_min_baseline, in_nat_baseline, zero pad
   input  logic [ikscache_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation, axis
   input  logic [ikscache_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_minimum, out_natural, out_min_baseline, out_nat_baseline, zero pad
   output logic [ikscache_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // hit
   output logic [ikscache_pkg::RSP_USER_W-1:0] rsp_tuser
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int DEPTH  = 2 * ENTRIES;
   localparam int ADDR_W = $clog2(DEPTH);

   // Miss answer: no hit, sizes zero, baselines -1.
   localparam ikscache_pkg::rsp_data_type MISS_DATA = '{zero_pad: '0, out_nat_baseline: '1,
                                                        out_min_baseline: '1, out_natural: '0,
                                                        out_minimum: '0};

   // One cached result with its key interval, all fields SIZE_BITS two's complement.
   typedef struct packed {
      logic signed [SIZE_BITS-1:0] lower;
      logic signed [SIZE_BITS-1:0] upper;
      logic signed [SIZE_BITS-1:0] minimum;
      logic signed [SIZE_BITS-1:0] natural;
      logic signed [SIZE_BITS-1:0] min_bl;
      logic signed [SIZE_BITS-1:0] nat_bl;
   } entry_type;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_RESP} state_type;

   // Low bits of a stored value as seen on the response fields.
   function automatic logic [14:0] out15(input logic signed [SIZE_BITS-1:0] v);
      logic signed [31:0] w;
      w = 32'(v);
      return w[14:0];
   endfunction

   function automatic logic [15:0] out16(input logic signed [SIZE_BITS-1:0] v);
      logic signed [31:0] w;
      w = 32'(v);
      return w[15:0];
   endfunction

   // Horizontal entries sit at 0..ENTRIES-1, vertical ones right above.
   function automatic logic [ADDR_W-1:0] addr_of(input logic ax, input logic [IDX_W-1:0] idx);
      return ax ? ADDR_W'(ENTRIES) + ADDR_W'(idx) : ADDR_W'(idx);
   endfunction

   state_type                   state_ff;
   entry_type                   mem [DEPTH];
   entry_type                   rd_data_ff;

   // Item being worked on.
   logic [1:0]                  op_ff;
   logic                        axis_ff;
   logic signed [SIZE_BITS-1:0] key_ff, mn_ff, nt_ff, mb_ff, nb_ff;
   logic [CNT_W-1:0]            n_ff;
   logic [IDX_W-1:0]            scan_idx_ff;

   // Per-axis control state.
   logic                        base_valid_ff [2];
   logic [CNT_W-1:0]            count_ff [2];
   logic [IDX_W-1:0]            ptr_ff [2];

   // Base results; only the vertical axis keeps baselines.
   logic signed [SIZE_BITS-1:0] base_min_ff [2];
   logic signed [SIZE_BITS-1:0] base_nat_ff [2];
   logic signed [SIZE_BITS-1:0] base_mb_ff, base_nb_ff;

   // Finished result, then the output register.
   logic                        res_hit_ff;
   ikscache_pkg::rsp_data_type  res_data_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_hit_ff;
   ikscache_pkg::rsp_data_type  rsp_data_ff;

   ikscache_pkg::req_data_type  req_fields;
   ikscache_pkg::req_user_type  req_sel;
   logic signed [31:0]          key_w, mb_w, nb_w;
   logic [31:0]                 mn_w, nt_w;
   logic signed [SIZE_BITS-1:0] key_fit, mn_fit, nt_fit, mb_fit, nb_fit;

   logic                        have, last, contains, same, full;
   logic [IDX_W-1:0]            ptr_cur, ptr_wrap, alloc_idx, scan_next;
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr, rd_addr;
   entry_type                   wr_data;

   logic                        base_hit, scan_start;
   ikscache_pkg::rsp_data_type  base_data, scan_data;

   // Unpack the request beat and bring each field to SIZE_BITS.
   always_comb begin
      req_fields = ikscache_pkg::req_data_type'(req_tdata);
      req_sel    = ikscache_pkg::req_user_type'(req_tuser);
      key_w      = 32'(signed'(req_fields.key_size));
      mn_w       = 32'(req_fields.in_minimum);
      nt_w       = 32'(req_fields.in_natural);
      if (req_sel.axis == ikscache_pkg::AXIS_V) begin
         mb_w = 32'(signed'(req_fields.in_min_baseline));
         nb_w = 32'(signed'(req_fields.in_nat_baseline));
      end else begin
         mb_w = -32'sd1;
         nb_w = -32'sd1;
      end
      key_fit = key_w[SIZE_BITS-1:0];
      mn_fit  = mn_w[SIZE_BITS-1:0];
      nt_fit  = nt_w[SIZE_BITS-1:0];
      mb_fit  = mb_w[SIZE_BITS-1:0];
      nb_fit  = nb_w[SIZE_BITS-1:0];
   end

   // Base answers at accept, and the entry answer once a scan finds a match.
   always_comb begin
      base_hit   = (req_sel.operation == ikscache_pkg::OP_LOOKUP) && (key_fit < 0) &&
                   base_valid_ff[req_sel.axis];
      scan_start = ((req_sel.operation == ikscache_pkg::OP_LOOKUP) ||
                    (req_sel.operation == ikscache_pkg::OP_COMMIT)) && (key_fit >= 0);
      base_data             = MISS_DATA;
      base_data.out_minimum = out15(base_min_ff[req_sel.axis]);
      base_data.out_natural = out15(base_nat_ff[req_sel.axis]);
      if (req_sel.axis == ikscache_pkg::AXIS_V) begin
         base_data.out_min_baseline = out16(base_mb_ff);
         base_data.out_nat_baseline = out16(base_nb_ff);
      end
      scan_data             = MISS_DATA;
      scan_data.out_minimum = out15(rd_data_ff.minimum);
      scan_data.out_natural = out15(rd_data_ff.natural);
      if (axis_ff == ikscache_pkg::AXIS_V) begin
         scan_data.out_min_baseline = out16(rd_data_ff.min_bl);
         scan_data.out_nat_baseline = out16(rd_data_ff.nat_bl);
      end
   end

   // Compare the entry that came back from memory with the held item.
   always_comb begin
      have      = CNT_W'(scan_idx_ff) < n_ff;
      last      = (CNT_W'(scan_idx_ff) + CNT_W'(1)) >= n_ff;
      contains  = have && (rd_data_ff.lower <= key_ff) && (rd_data_ff.upper >= key_ff);
      same      = have && (rd_data_ff.minimum == mn_ff) && (rd_data_ff.natural == nt_ff) &&
                  ((axis_ff == ikscache_pkg::AXIS_H) ||
                   ((rd_data_ff.min_bl == mb_ff) && (rd_data_ff.nat_bl == nb_ff)));
      full      = n_ff == CNT_W'(ENTRIES);
      ptr_cur   = ptr_ff[axis_ff];
      ptr_wrap  = (ptr_cur == IDX_W'(ENTRIES - 1)) ? '0 : ptr_cur + IDX_W'(1);
      alloc_idx = full ? ptr_wrap : n_ff[IDX_W-1:0];
      scan_next = scan_idx_ff + IDX_W'(1);
   end

   // On a commit, write back a widened entry on a match, or fill/replace one after the last compare.
   always_comb begin
      wr_en   = (state_ff == ST_SCAN) && (op_ff == ikscache_pkg::OP_COMMIT) && (same || last);
      wr_addr = addr_of(axis_ff, same ? scan_idx_ff : alloc_idx);
      if (same) begin
         wr_data       = rd_data_ff;
         wr_data.lower = (key_ff < rd_data_ff.lower) ? key_ff : rd_data_ff.lower;
         wr_data.upper = (key_ff > rd_data_ff.upper) ? key_ff : rd_data_ff.upper;
      end else begin
         wr_data = '{lower: key_ff, upper: key_ff, minimum: mn_ff, natural: nt_ff,
                     min_bl: mb_ff, nat_bl: nb_ff};
      end
      // Start at entry 0 on accept, then prefetch the next entry each scan cycle.
      rd_addr = (state_ff == ST_SCAN) ? addr_of(axis_ff, scan_next)
                                      : addr_of(req_sel.axis, '0);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         base_valid_ff <= '{default: 1'b0};
         count_ff      <= '{default: '0};
         ptr_ff        <= '{default: '0};
      end else begin
         // Drop the response once it is taken, unless a new one moves in this cycle.
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  op_ff       <= req_sel.operation;
                  axis_ff     <= req_sel.axis;
                  key_ff      <= key_fit;
                  mn_ff       <= mn_fit;
                  nt_ff       <= nt_fit;
                  mb_ff       <= mb_fit;
                  nb_ff       <= nb_fit;
                  n_ff        <= count_ff[req_sel.axis];
                  scan_idx_ff <= '0;
                  // Preload the miss result unless the base answers right away.
                  res_hit_ff  <= base_hit;
                  res_data_ff <= base_hit ? base_data : MISS_DATA;
                  state_ff    <= scan_start ? ST_SCAN : ST_RESP;
                  unique case (req_sel.operation)
                     ikscache_pkg::OP_LOOKUP: begin
                        // Answered above from the base, or by the scan.
                     end
                     ikscache_pkg::OP_COMMIT: begin
                        if (key_fit < 0) begin
                           base_min_ff[req_sel.axis]   <= mn_fit;
                           base_nat_ff[req_sel.axis]   <= nt_fit;
                           base_valid_ff[req_sel.axis] <= 1'b1;
                           if (req_sel.axis == ikscache_pkg::AXIS_V) begin
                              base_mb_ff <= mb_fit;
                              base_nb_ff <= nb_fit;
                           end
                        end
                     end
                     ikscache_pkg::OP_CLEAR: begin
                        base_valid_ff <= '{default: 1'b0};
                        count_ff      <= '{default: '0};
                        ptr_ff        <= '{default: '0};
                     end
                     default: begin
                        // Unused code: answer as a miss, touch nothing.
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (op_ff == ikscache_pkg::OP_LOOKUP) begin
                  if (contains) begin
                     res_hit_ff  <= 1'b1;
                     res_data_ff <= scan_data;
                     state_ff    <= ST_RESP;
                  end else if (last) begin
                     state_ff <= ST_RESP;
                  end else begin
                     scan_idx_ff <= scan_next;
                  end
               end else begin
                  if (same) begin
                     state_ff <= ST_RESP;
                  end else if (last) begin
                     if (!full) begin
                        count_ff[axis_ff] <= n_ff + CNT_W'(1);
                     end
                     ptr_ff[axis_ff] <= alloc_idx;
                     state_ff        <= ST_RESP;
                  end else begin
                     scan_idx_ff <= scan_next;
                  end
               end
            end
            ST_RESP: begin
               // Hold the result until the output register is free.
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff   <= res_hit_ff;
                  rsp_data_ff  <= res_data_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

[design/ikscache_chk.sv]
// Port-level checker for the interval-keyed size cache, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ikscache_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [ikscache_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [ikscache_pkg::RSP_USER_W-1:0] rsp_tuser
);

   logic [1:0] pend_ff;
   logic [1:0] pend_in;

   // Track beats accepted but not yet answered.
   always_comb begin
      pend_in = pend_ff;
      if (req_tvalid && req_tready) begin
         pend_in = pend_in + 2'd1;
      end
      if (rsp_tvalid && rsp_tready) begin
         pend_in = pend_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `ASSERT_CHK(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")
   `ASSERT_CHK(a_miss_shape, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[29:0] == 30'd0 && rsp_tdata[61:30] == 32'hFFFF_FFFF, "miss response carries data")
   `ASSERT_CHK(a_no_spurious, rsp_tvalid |-> pend_ff != 2'd0, "response without an accepted request")
   `ASSERT_CHK(a_pend_bound, pend_ff != 2'd3, "more than two requests outstanding")

endmodule

bind interval_keyed_size_cache ikscache_chk u_ikscache_chk (.*);

[test/tb.sv]
// Self-checking testbench for the interval-keyed size cache stream block.
`timescale 1ns / 1ps

module tb;

   localparam int CACHE_ENTRIES = 4;
   localparam int CACHE_SIZE_BITS = 16;
   localparam int RANDOM_ITEMS = 1600;
   localparam int QUIET_ITEMS = 200;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 3 * (2 + CACHE_ENTRIES) + 4;
   // operation code the block must ignore
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // One stored interval and its size result, as the cache holds it.
   typedef struct packed {
      logic [15:0] lower;
      logic [15:0] upper;
      logic [15:0] minimum;
      logic [15:0] natural;
      logic [15:0] min_bl;
      logic [15:0] nat_bl;
   } size_slot_type;

   typedef struct packed {
      logic                       hit;
      ikscache_pkg::rsp_data_type data;
   } cache_reply_type;

   // Tracks both axes of the cache and the replies still owed by the block.
   class cache_tracker_type;
      size_slot_type   slots[2 * CACHE_ENTRIES];
      logic            base_ok[2];
      logic [15:0]     base_min[2];
      logic [15:0]     base_nat[2];
      logic [15:0]     base_mbl[2];
      logic [15:0]     base_nbl[2];
      int unsigned     fill[2];
      int unsigned     ptr[2];
      cache_reply_type awaited_replies[$];
      int              failures;

      function new();
         failures = 0;
         wipe();
      endfunction

      // Forget everything; stored values stay but the fill counts hide them.
      function void wipe();
         for (int a = 0; a < 2; a++) begin
            base_ok[a] = 1'b0;
            fill[a] = 0;
            ptr[a] = 0;
         end
      endfunction

      function cache_reply_type hit_reply(input logic [15:0] mn, input logic [15:0] nt,
                                          input logic [15:0] mb, input logic [15:0] nb);
         cache_reply_type r;
         r = '0;
         r.hit = 1'b1;
         r.data.out_minimum = mn[14:0];
         r.data.out_natural = nt[14:0];
         r.data.out_min_baseline = mb;
         r.data.out_nat_baseline = nb;
         return r;
      endfunction

      // Apply one accepted request and queue the reply it must produce.
      function void take_request(input logic [1:0] op, input logic ax,
                                 input logic [15:0] key, input logic [14:0] mn,
                                 input logic [14:0] nt, input logic [15:0] mb_in,
                                 input logic [15:0] nb_in);
         cache_reply_type r;
         logic [15:0]     mb, nb, smn, snt;
         int unsigned     n, at, base;
         logic            found;
         r = '0;
         r.data.out_min_baseline = 16'hFFFF;
         r.data.out_nat_baseline = 16'hFFFF;
         // horizontal entries carry no baselines
         mb = (ax == ikscache_pkg::AXIS_V) ? mb_in : 16'hFFFF;
         nb = (ax == ikscache_pkg::AXIS_V) ? nb_in : 16'hFFFF;
         smn = {1'b0, mn};
         snt = {1'b0, nt};
         n = fill[ax];
         base = int'(ax) * CACHE_ENTRIES;
         found = 1'b0;
         case (op)
            ikscache_pkg::OP_CLEAR: wipe();
            ikscache_pkg::OP_LOOKUP: begin
               if (key[15]) begin
                  if (base_ok[ax])
                     r = hit_reply(base_min[ax], base_nat[ax], base_mbl[ax], base_nbl[ax]);
               end else begin
                  for (int i = 0; i < n && !found; i++) begin
                     at = base + i;
                     if ($signed(slots[at].lower) <= $signed(key) &&
                         $signed(slots[at].upper) >= $signed(key)) begin
                        found = 1'b1;
                        r = hit_reply(slots[at].minimum, slots[at].natural,
                                      slots[at].min_bl, slots[at].nat_bl);
                     end
                  end
               end
            end
            ikscache_pkg::OP_COMMIT: begin
               if (key[15]) begin
                  base_min[ax] = smn;
                  base_nat[ax] = snt;
                  base_mbl[ax] = mb;
                  base_nbl[ax] = nb;
                  base_ok[ax] = 1'b1;
               end else begin
                  // widen the first entry holding the same result
                  for (int i = 0; i < n && !found; i++) begin
                     at = base + i;
                     if (slots[at].minimum == smn && slots[at].natural == snt &&
                         (ax == ikscache_pkg::AXIS_H ||
                          (slots[at].min_bl == mb && slots[at].nat_bl == nb)))
                     begin
                        found = 1'b1;
                        if ($signed(key) < $signed(slots[at].lower)) slots[at].lower = key;
                        if ($signed(key) > $signed(slots[at].upper)) slots[at].upper = key;
                     end
                  end
                  if (!found) begin
                     if (n < CACHE_ENTRIES) begin
                        fill[ax] = n + 1;
                        ptr[ax] = n;
                     end else begin
                        ptr[ax] = (ptr[ax] + 1 >= CACHE_ENTRIES) ? 0 : ptr[ax] + 1;
                     end
                     at = base + ptr[ax];
                     slots[at].lower = key;
                     slots[at].upper = key;
                     slots[at].minimum = smn;
                     slots[at].natural = snt;
                     slots[at].min_bl = mb;
                     slots[at].nat_bl = nb;
                  end
               end
            end
            default: ;
         endcase
         awaited_replies.push_back(r);
      endfunction

      // Compare one accepted reply beat with the oldest outstanding reply.
      function void match_reply(input logic hit, input ikscache_pkg::rsp_data_type got);
         cache_reply_type want;
         if (awaited_replies.size() == 0) begin
            if (failures < 10)
               $display("unexpected reply: hit=%0b min=%0d nat=%0d mbl=%0d nbl=%0d",
                        hit, got.out_minimum, got.out_natural,
                        $signed(got.out_min_baseline), $signed(got.out_nat_baseline));
            failures++;
         end else begin
            want = awaited_replies.pop_front();
            if (want.hit !== hit ||
                want.data.out_minimum !== got.out_minimum ||
                want.data.out_natural !== got.out_natural ||
                want.data.out_min_baseline !== got.out_min_baseline ||
                want.data.out_nat_baseline !== got.out_nat_baseline) begin
               if (failures < 10) begin
                  $display("reply mismatch: expected hit=%0b min=%0d nat=%0d mbl=%0d nbl=%0d",
                           want.hit, want.data.out_minimum, want.data.out_natural,
                           $signed(want.data.out_min_baseline),
                           $signed(want.data.out_nat_baseline));
                  $display("                got      hit=%0b min=%0d nat=%0d mbl=%0d nbl=%0d",
                           hit, got.out_minimum, got.out_natural,
                           $signed(got.out_min_baseline), $signed(got.out_nat_baseline));
               end
               failures++;
            end
         end
      endfunction

      function int pending();
         return awaited_replies.size();
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [ikscache_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [ikscache_pkg::REQ_USER_W-1:0] req_tuser = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [ikscache_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [ikscache_pkg::RSP_USER_W-1:0] rsp_tuser;

   cache_tracker_type board;
   logic              quiet_tail = 1'b0;
   int                stall_left = 0;
   int                cycle_count;

   interval_keyed_size_cache #(
      .ENTRIES  (CACHE_ENTRIES),
      .SIZE_BITS(CACHE_SIZE_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Reply side: check each accepted beat, then stall in random bursts.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.match_reply(rsp_tuser[0], rsp_tdata);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(0, 13);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Present one request beat, hold it until accepted, then maybe idle a burst.
   task automatic send_item(input logic [1:0] op, input logic ax, input logic [15:0] key,
                            input logic [14:0] mn, input logic [14:0] nt,
                            input logic [15:0] mb, input logic [15:0] nb);
      ikscache_pkg::req_data_type d;
      ikscache_pkg::req_user_type u;
      d = '0;
      d.key_size = key;
      d.in_minimum = mn;
      d.in_natural = nt;
      d.in_min_baseline = mb;
      d.in_nat_baseline = nb;
      u.operation = op;
      u.axis = ax;
      req_tdata <= d;
      req_tuser <= u;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_request(op, ax, key, mn, nt, mb, nb);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // Mostly well-formed traffic: small keys and a small pool of results so that
   // commits widen, fill and wrap entries and lookups hit; the rest is noise.
   task automatic random_item();
      int          pick, idx;
      logic [1:0]  op;
      logic        ax;
      logic [15:0] key, mb, nb;
      logic [14:0] mn, nt;
      pick = $urandom_range(0, 99);
      if (pick < 2) op = ikscache_pkg::OP_CLEAR;
      else if (pick < 4) op = OP_UNUSED;
      else if (pick < 50) op = ikscache_pkg::OP_LOOKUP;
      else op = ikscache_pkg::OP_COMMIT;
      ax = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 8) key = {1'b1, 15'($urandom)};
      else if (pick < 12) key = 16'($urandom);
      else key = 16'($urandom_range(0, 24));
      mn = 15'($urandom);
      nt = 15'($urandom);
      mb = 16'($urandom);
      nb = 16'($urandom);
      if (op == ikscache_pkg::OP_COMMIT && $urandom_range(0, 99) < 80) begin
         idx = $urandom_range(0, 5);
         mn = 15'(idx * 3);
         nt = 15'(7 - idx);
         mb = idx[0] ? 16'hFFFF : 16'(idx);
         nb = (idx > 3) ? 16'hFFFF : 16'(idx * 2);
      end
      send_item(op, ax, key, mn, nt, mb, nb);
   endtask

   // Hold the request side until every outstanding reply has come back.
   task automatic drain_hold();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty cache: base and entry lookups miss
      send_item(ikscache_pkg::OP_LOOKUP, ikscache_pkg::AXIS_H, 16'h8000, 15'h7FFF, 15'h7FFF,
                16'hFFFF, 16'hFFFF);
      send_item(ikscache_pkg::OP_LOOKUP, ikscache_pkg::AXIS_V, 16'd0, 15'd0, 15'd0,
                16'd0, 16'd0);
      // base results; horizontal drops its baselines
      send_item(ikscache_pkg::OP_COMMIT, ikscache_pkg::AXIS_H, 16'hFFFF, 15'h7FFF, 15'd0,
                16'h1234, 16'h8000);
      send_item(ikscache_pkg::OP_LOOKUP, ikscache_pkg::AXIS_H, 16'h8000, 15'd0, 15'd0,
                16'd0, 16'd0);
      send_item(ikscache_pkg::OP_COMMIT, ikscache_pkg::AXIS_V, 16'hFFFB, 15'd0, 15'h7FFF,
                16'h7FFF, 16'hFFFF);
      send_item(ikscache_pkg::OP_LOOKUP, ikscache_pkg::AXIS_V, 16'hFFFF, 15'd0, 15'd0,
                16'd0, 16'd0);
      // vertical entry widened from 0 to the top key, then a second one that
      // differs only in baselines
      send_item(ikscache_pkg::OP_COMMIT, ikscache_pkg::AXIS_V, 16'd0, 15'd5, 15'd6,
                16'h8000, 16'h7FFF);
      send_item(ikscache_pkg::OP_COMMIT, ikscache_pkg::AXIS_V, 16'h7FFF, 15'd5, 15'd6,
                16'h8000, 16'h7FFF);
      send_item(ikscache_pkg::OP_LOOKUP, ikscache_pkg::AXIS_V, 16'd100, 15'd0, 15'd0,
                16'd0, 16'd0);
      send_item(ikscache_pkg::OP_COMMIT, ikscache_pkg::AXIS_V, 16'd10, 15'd5, 15'd6,
                16'd0, 16'd0);
      // fill the horizontal axis, then wrap round robin onto entry 0
      for (int i = 1; i <= 5; i++)
         send_item(ikscache_pkg::OP_COMMIT, ikscache_pkg::AXIS_H, 16'(i), 15'(i), 15'(i),
                   16'($urandom), 16'($urandom));
      send_item(ikscache_pkg::OP_LOOKUP, ikscache_pkg::AXIS_H, 16'd1, 15'd0, 15'd0,
                16'd0, 16'd0);
      send_item(ikscache_pkg::OP_LOOKUP, ikscache_pkg::AXIS_H, 16'd5, 15'd0, 15'd0,
                16'd0, 16'd0);
      // widen entry 1 over key 3 so that the first containing entry wins
      send_item(ikscache_pkg::OP_COMMIT, ikscache_pkg::AXIS_H, 16'd3, 15'd2, 15'd2,
                16'h5555, 16'hAAAA);
      send_item(ikscache_pkg::OP_LOOKUP, ikscache_pkg::AXIS_H, 16'd3, 15'd0, 15'd0,
                16'd0, 16'd0);
      // unused code, then clear both axes
      send_item(OP_UNUSED, ikscache_pkg::AXIS_V, 16'hFFFF, 15'h7FFF, 15'h7FFF,
                16'hFFFF, 16'hFFFF);
      send_item(ikscache_pkg::OP_CLEAR, ikscache_pkg::AXIS_H, 16'd0, 15'd0, 15'd0,
                16'd0, 16'd0);
      send_item(ikscache_pkg::OP_LOOKUP, ikscache_pkg::AXIS_V, 16'hFFFF, 15'd0, 15'd0,
                16'd0, 16'd0);
      send_item(ikscache_pkg::OP_LOOKUP, ikscache_pkg::AXIS_H, 16'd5, 15'd0, 15'd0,
                16'd0, 16'd0);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 3 || k == 2 * RANDOM_ITEMS / 3)
            drain_hold();
         if (k == RANDOM_ITEMS - QUIET_ITEMS)
            quiet_tail = 1'b1;
         random_item();
      end
      req_tvalid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
